[src/rbm_pkg.sv]
// Package for the RGB box mean filter: word types, register codes, field
// widths and the border padding function. No dependencies.
`timescale 1ns / 1ps
package rbm_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 7;
  localparam int MAX_HEIGHT     = 4096;

  // coordinate width that covers padded rows and columns
  localparam int CRD_W     = 14;
  localparam int FW_W      = 11;
  localparam int FH_W      = 13;
  localparam int FR_W      = 3;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] chan0_in;
    logic [7:0] chan1_in;
    logic [7:0] chan2_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] chan0_mean;
    logic [7:0] chan1_mean;
    logic [7:0] chan2_mean;
    logic       frame_end;
  } out_word_t;

  typedef struct packed {
    logic clear;
    logic acc_en;
    logic div_step;
  } lane_ctrl_t;

  // Map a padded coordinate q to a frame coordinate for extent n, radius r.
  function automatic logic [CRD_W-1:0] pad_src(input logic [CRD_W-1:0] q,
                                               input logic [CRD_W-1:0] n,
                                               input logic [CRD_W-1:0] r);
    logic [CRD_W-1:0] s;
    if (q < r) begin
      s = q;
    end else if (q < r + n) begin
      s = q - r;
    end else if (q >= (r << 1)) begin
      s = q - (r << 1);
    end else begin
      s = '0;
    end
    if (s > n - 1'b1) begin
      s = n - 1'b1;
    end
    return s;
  endfunction

endpackage

[src/rbm_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rbm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

[src/rbm_lane.sv]
// One channel lane: window sum accumulator and restoring divider by the area.
// Depends on rbm_pkg.
`timescale 1ns / 1ps
module rbm_lane #(
  parameter int SUM_W  = 18,
  parameter int AREA_W = 8
) (
  input  logic               clk_i,
  input  rbm_pkg::lane_ctrl_t ctrl_i,
  input  logic [7:0]         pix_i,
  input  logic [AREA_W-1:0]  area_i,
  output logic [7:0]         mean_o
);

  logic [SUM_W-1:0]  acc_q;
  logic [AREA_W:0]   rem_q;
  logic [AREA_W:0]   rem_sh;
  logic              ge;

  // shift in the next dividend bit and compare against the area
  assign rem_sh = {rem_q[AREA_W-1:0], acc_q[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, area_i};

  // accumulate, then divide in place: quotient bits replace the sum
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      acc_q <= '0;
      rem_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_q + SUM_W'(pix_i);
    end else if (ctrl_i.div_step) begin
      acc_q <= {acc_q[SUM_W-2:0], ge};
      rem_q <= ge ? (rem_sh - {1'b0, area_i}) : rem_sh;
    end
  end

  assign mean_o = acc_q[7:0];

endmodule

[src/rgb_box_mean_filter.sv]
// Top level of the RGB box mean filter: row ring store, window sequencer,
// three channel lanes and the output register. Depends on rbm_pkg, rbm_ram, rbm_lane.
// A word without a result leaves the block idle for the next word. A word with a result
// starts a window pass (S_SUM, S_DRAIN, S_DIV, S_DONE): one window pixel read a cycle, then
// the bit-per-cycle divider (SUM_W = 16 at the default radius limit), then the output load.
// Reset: registers to 640 x 480, radius 1, frame positions zero; row store not cleared.
`timescale 1ns / 1ps
module rgb_box_mean_filter #(
  parameter int MAX_WIDTH  = rbm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = rbm_pkg::MAX_RADIUS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rbm_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rbm_pkg::out_word_t             out_word_o,
  input  logic                           cfg_we_i,
  input  logic [rbm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rbm_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int CRD_W  = rbm_pkg::CRD_W;
  localparam int FH_W   = rbm_pkg::FH_W;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WU_W   = COL_W + 1;
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int SIDE_W = RAD_W + 1;
  localparam int AREA_W = 2 * SIDE_W;
  localparam int RING   = 3 * MAX_RADIUS + 1;
  localparam int RING_W = $clog2(RING);
  localparam int DEPTH  = RING * (2 ** COL_W);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SUM_W  = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * 255 + 1);
  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam int CNT_W  = FH_W + WU_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // configuration registers
  logic [rbm_pkg::FW_W-1:0] fw_q;
  logic [FH_W-1:0]          fh_q;
  logic [rbm_pkg::FR_W-1:0] fr_q;

  // frame positions
  logic [FH_W-1:0]   in_row_q, out_row_q;
  logic [COL_W-1:0]  in_col_q, out_col_q;
  logic [RING_W-1:0] in_ring_q, out_ring_q;
  logic [CNT_W-1:0]  cnt_q;

  // sequencer
  logic [2:0]        state_q;
  logic [SIDE_W-1:0] dy_q, dx_q;
  logic [RING_W-1:0] rring_q;
  logic [STEP_W-1:0] step_q;
  logic              rd_v_q;
  logic              out_valid_q;
  rbm_pkg::out_word_t out_word_q;
  logic              fend_q;

  // used geometry
  logic [CRD_W-1:0]  w_c, r_c;
  logic [WU_W-1:0]   w_used;
  logic [FH_W-1:0]   h_used;
  logic [RAD_W-1:0]  r_used;
  logic [SIDE_W-1:0] side;
  logic [AREA_W-1:0] area;
  logic [CNT_W-1:0]  lag;

  always_comb begin
    w_c = CRD_W'(fw_q);
    if (w_c == '0) begin
      w_c = CRD_W'(1);
    end else if (w_c > CRD_W'(MAX_WIDTH)) begin
      w_c = CRD_W'(MAX_WIDTH);
    end
    if (fh_q == '0) begin
      h_used = FH_W'(1);
    end else if (fh_q > FH_W'(rbm_pkg::MAX_HEIGHT)) begin
      h_used = FH_W'(rbm_pkg::MAX_HEIGHT);
    end else begin
      h_used = fh_q;
    end
    r_c = CRD_W'(fr_q);
    if (r_c > CRD_W'(MAX_RADIUS)) begin
      r_c = CRD_W'(MAX_RADIUS);
    end
  end

  assign w_used = WU_W'(w_c);
  assign r_used = RAD_W'(r_c);
  assign side   = {r_used, 1'b1};
  assign area   = AREA_W'(side) * AREA_W'(side);
  assign lag    = CNT_W'(r_used) * CNT_W'(w_used) + CNT_W'(r_used);

  // ring row holding padded window row dy of output row orow
  function automatic logic [RING_W-1:0] row_ring(input logic [SIDE_W-1:0] dy,
                                                 input logic [FH_W-1:0]   orow,
                                                 input logic [RING_W-1:0] oring,
                                                 input logic [FH_W-1:0]   h,
                                                 input logic [CRD_W-1:0]  r);
    logic [CRD_W-1:0] s;
    logic [CRD_W-1:0] t;
    s = rbm_pkg::pad_src(CRD_W'(orow) + CRD_W'(dy), CRD_W'(h), r);
    // biased by RING so the offset from the output row stays positive
    t = CRD_W'(oring) + s + CRD_W'(RING) - CRD_W'(orow);
    if (t >= CRD_W'(2 * RING)) begin
      t = t - CRD_W'(2 * RING);
    end else if (t >= CRD_W'(RING)) begin
      t = t - CRD_W'(RING);
    end
    return RING_W'(t);
  endfunction

  // input word decode
  logic              in_acc, is_flush, frame_done, restart_in, emit;
  logic [FH_W-1:0]   row_e, orow_e;
  logic [COL_W-1:0]  col_e, ocol_e;
  logic [RING_W-1:0] ring_e, oring_e;
  logic [CNT_W-1:0]  cnt_e;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_flush   = (in_word_i.command == rbm_pkg::CMD_FLUSH);
  assign frame_done = (in_row_q >= h_used);
  assign restart_in = frame_done || (WU_W'(in_col_q) >= w_used);

  always_comb begin
    if (!is_flush && restart_in) begin
      row_e = '0; col_e = '0; ring_e = '0; cnt_e = '0;
      orow_e = '0; ocol_e = '0; oring_e = '0;
    end else begin
      row_e = in_row_q; col_e = in_col_q; ring_e = in_ring_q; cnt_e = cnt_q;
      orow_e = out_row_q; ocol_e = out_col_q; oring_e = out_ring_q;
    end
    emit = is_flush ? frame_done : (cnt_e >= lag);
  end

  // window column address
  logic [CRD_W-1:0]  sx;
  logic [ADDR_W-1:0] ram_addr;
  logic              ram_we;
  logic [23:0]       ram_rdata;

  assign sx     = rbm_pkg::pad_src(CRD_W'(out_col_q) + CRD_W'(dx_q), w_c, r_c);
  assign ram_we = in_acc && !is_flush;
  assign ram_addr = (state_q == S_IDLE) ? ADDR_W'({ring_e, col_e})
                                        : ADDR_W'({rring_q, COL_W'(sx)});

  rbm_ram #(
    .WIDTH(24),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i({in_word_i.chan2_in, in_word_i.chan1_in, in_word_i.chan0_in}),
    .rdata_o(ram_rdata)
  );

  // lanes, one per channel
  rbm_pkg::lane_ctrl_t lane_ctrl;
  logic [7:0] mean0, mean1, mean2;

  assign lane_ctrl.clear    = in_acc && emit;
  assign lane_ctrl.acc_en   = rd_v_q;
  assign lane_ctrl.div_step = (state_q == S_DIV);

  rbm_lane #(.SUM_W(SUM_W), .AREA_W(AREA_W)) u_lane0 (
    .clk_i(clk_i), .ctrl_i(lane_ctrl), .pix_i(ram_rdata[7:0]),
    .area_i(area), .mean_o(mean0)
  );
  rbm_lane #(.SUM_W(SUM_W), .AREA_W(AREA_W)) u_lane1 (
    .clk_i(clk_i), .ctrl_i(lane_ctrl), .pix_i(ram_rdata[15:8]),
    .area_i(area), .mean_o(mean1)
  );
  rbm_lane #(.SUM_W(SUM_W), .AREA_W(AREA_W)) u_lane2 (
    .clk_i(clk_i), .ctrl_i(lane_ctrl), .pix_i(ram_rdata[23:16]),
    .area_i(area), .mean_o(mean2)
  );

  logic load_out, out_acc, last_col, last_row;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign last_col = (WU_W'(out_col_q) + 1'b1 >= w_used);
  assign last_row = (out_row_q + 1'b1 >= h_used);

  // sequencer and frame positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= rbm_pkg::FW_W'(640);
      fh_q <= FH_W'(480);
      fr_q <= rbm_pkg::FR_W'(1);
      in_row_q <= '0; in_col_q <= '0; in_ring_q <= '0; cnt_q <= '0;
      out_row_q <= '0; out_col_q <= '0; out_ring_q <= '0;
      state_q <= S_IDLE; dy_q <= '0; dx_q <= '0; rring_q <= '0; step_q <= '0;
      rd_v_q <= 1'b0; out_valid_q <= 1'b0; fend_q <= 1'b0;
    end else begin
      rd_v_q <= (state_q == S_SUM);
      if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (!is_flush) begin
              out_row_q <= orow_e; out_col_q <= ocol_e; out_ring_q <= oring_e;
              cnt_q <= cnt_e + 1'b1;
              if (WU_W'(col_e) + 1'b1 >= w_used) begin
                in_col_q <= '0;
                in_row_q <= row_e + 1'b1;
                in_ring_q <= (ring_e == RING_W'(RING - 1)) ? '0 : ring_e + 1'b1;
              end else begin
                in_col_q <= col_e + 1'b1;
                in_row_q <= row_e;
                in_ring_q <= ring_e;
              end
            end
            if (emit) begin
              state_q <= S_SUM;
              dy_q <= '0;
              dx_q <= '0;
              rring_q <= row_ring('0, orow_e, oring_e, h_used, r_c);
              fend_q <= (orow_e == h_used - 1'b1) && (WU_W'(ocol_e) + 1'b1 == w_used);
            end
          end
        end
        S_SUM: begin
          if (dx_q == side - 1'b1) begin
            dx_q <= '0;
            if (dy_q == side - 1'b1) begin
              state_q <= S_DRAIN;
            end else begin
              dy_q <= dy_q + 1'b1;
              rring_q <= row_ring(dy_q + 1'b1, out_row_q, out_ring_q, h_used, r_c);
            end
          end else begin
            dx_q <= dx_q + 1'b1;
          end
        end
        S_DRAIN: begin
          state_q <= S_DIV;
          step_q <= '0;
        end
        S_DIV: begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(SUM_W - 1)) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            out_valid_q <= 1'b1;
            state_q <= S_IDLE;
            // advance the output position, restart after the last row
            if (last_col) begin
              out_col_q <= '0;
              if (last_row) begin
                out_row_q <= '0; out_ring_q <= '0;
                in_row_q <= '0; in_col_q <= '0; in_ring_q <= '0; cnt_q <= '0;
              end else begin
                out_row_q <= out_row_q + 1'b1;
                out_ring_q <= (out_ring_q == RING_W'(RING - 1)) ? '0 : out_ring_q + 1'b1;
              end
            end else begin
              out_col_q <= out_col_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      // register write restarts the frame
      if (cfg_we_i && (cfg_index_i == rbm_pkg::CFG_WIDTH ||
                       cfg_index_i == rbm_pkg::CFG_HEIGHT ||
                       cfg_index_i == rbm_pkg::CFG_RADIUS)) begin
        if (cfg_index_i == rbm_pkg::CFG_WIDTH) begin
          fw_q <= cfg_data_i[rbm_pkg::FW_W-1:0];
        end else if (cfg_index_i == rbm_pkg::CFG_HEIGHT) begin
          fh_q <= cfg_data_i[FH_W-1:0];
        end else begin
          fr_q <= cfg_data_i[rbm_pkg::FR_W-1:0];
        end
        in_row_q <= '0; in_col_q <= '0; in_ring_q <= '0; cnt_q <= '0;
        out_row_q <= '0; out_col_q <= '0; out_ring_q <= '0;
      end
    end
  end

  // merge the lane results into the output word
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_word_q.chan0_mean <= mean0;
      out_word_q.chan1_mean <= mean1;
      out_word_q.chan2_mean <= mean2;
      out_word_q.frame_end  <= fend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[src/rbm_check.sv]
// Port-level checks for the RGB box mean filter, bound to the top level.
// Depends on rbm_pkg and rgb_box_mean_filter.
`timescale 1ns / 1ps
module rbm_check (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input rbm_pkg::in_word_t             in_word_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input rbm_pkg::out_word_t            out_word_o,
  input logic                          cfg_we_i,
  input logic [rbm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [rbm_pkg::CFG_W-1:0]     cfg_data_i
);

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // a word never produces its result in the following cycle
  a_no_fast_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("output appeared one cycle after an input word");

  // a new result only comes out of a busy window pass
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output rose while the block was idle");

endmodule

bind rgb_box_mean_filter rbm_check u_rbm_check (.*);

[test/tb_top.sv]
// Self-checking bench for rgb_box_mean_filter: random and table-driven pixel words,
// a per-pixel window mean predictor and an in-order result scoreboard.
// Depends on rbm_pkg and the filter RTL.
`timescale 1ns / 1ps
module tb_top;

  localparam int RING_ROWS = 22;
  localparam int SETTLE    = 300;
  localparam int ITEM_GOAL = 1350;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  rbm_pkg::in_word_t   in_word_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  rbm_pkg::out_word_t  out_word_o;
  logic       cfg_we_i = 1'b0;
  logic [rbm_pkg::CFG_IDX_W-1:0] cfg_index_i = rbm_pkg::CFG_WIDTH;
  logic [rbm_pkg::CFG_W-1:0]     cfg_data_i = '0;

  rgb_box_mean_filter uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_word_o(out_word_o),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [23:0] ring_px [0:RING_ROWS-1][0:1023];
  logic [rbm_pkg::FW_W-1:0] fw_reg;
  logic [rbm_pkg::FH_W-1:0] fh_reg;
  logic [rbm_pkg::FR_W-1:0] fr_reg;
  int in_row, in_col, out_row, out_col;

  rbm_pkg::out_word_t mean_q[$];
  int errors = 0;
  int words_done = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  logic squeeze_req = 1'b0;
  logic squeeze_done = 1'b0;
  int hold_left = 0;

  typedef struct {
    rbm_pkg::in_word_t  word;
    bit                 typed;
    rbm_pkg::out_word_t result;
  } stim_row_t;

  function automatic int eff_width();
    return (fw_reg == 0) ? 1 : ((fw_reg > 1024) ? 1024 : int'(fw_reg));
  endfunction

  function automatic int eff_height();
    return (fh_reg == 0) ? 1 :
           ((fh_reg > rbm_pkg::MAX_HEIGHT) ? rbm_pkg::MAX_HEIGHT : int'(fh_reg));
  endfunction

  function automatic void restart_pos();
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
  endfunction

  // map a padded coordinate back into the frame, copying edge rows in order (not mirrored)
  function automatic int fold_coord(int q, int n, int r);
    int s;
    if (q < r) s = q;
    else if (q < r + n) s = q - r;
    else s = (q >= 2 * r) ? q - 2 * r : 0;
    if (s > n - 1) s = n - 1;
    return s;
  endfunction

  function automatic rbm_pkg::out_word_t window_mean(int w, int h, int r);
    rbm_pkg::out_word_t o;
    int side, area, s0, s1, s2, sy, sx;
    logic [23:0] px;
    side = 2 * r + 1;
    area = side * side;
    s0 = 0; s1 = 0; s2 = 0;
    for (int dy = 0; dy < side; dy++) begin
      sy = fold_coord(out_row + dy, h, r);
      for (int dx = 0; dx < side; dx++) begin
        sx = fold_coord(out_col + dx, w, r);
        px = ring_px[sy % RING_ROWS][sx];
        s0 += px[7:0]; s1 += px[15:8]; s2 += px[23:16];
      end
    end
    o.chan0_mean = 8'(s0 / area);
    o.chan1_mean = 8'(s1 / area);
    o.chan2_mean = 8'(s2 / area);
    o.frame_end  = (out_row == h - 1 && out_col == w - 1);
    // advance the output position
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (out_row >= h) restart_pos();
    return o;
  endfunction

  function automatic bit filter_step(input rbm_pkg::in_word_t wd,
                                     output rbm_pkg::out_word_t o);
    int w, h, r, n;
    w = eff_width();
    h = eff_height();
    r = int'(fr_reg);
    o = '0;
    if (wd.command == rbm_pkg::CMD_FLUSH) begin
      if (in_row >= h) begin
        o = window_mean(w, h, r);
        return 1'b1;
      end
      return 1'b0;
    end
    if (in_row >= h || in_col >= w) restart_pos();
    ring_px[in_row % RING_ROWS][in_col] = {wd.chan2_in, wd.chan1_in, wd.chan0_in};
    n = in_row * w + in_col;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (n >= r * w + r) begin
      o = window_mean(w, h, r);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // offer one word, hold it until taken, then update the prediction
  task automatic send_word(input rbm_pkg::in_word_t wd, output bit has,
                           output rbm_pkg::out_word_t res);
    bit go;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= wd;
    do begin
      @(negedge clk_i);
      go = !in_stall_o;
      @(posedge clk_i);
    end while (!go);
    has = filter_step(wd, res);
  endtask

  task automatic feed(input rbm_pkg::in_word_t wd);
    bit has;
    rbm_pkg::out_word_t res;
    send_word(wd, has, res);
    if (has) mean_q.push_back(res);
    if (has || wd.command == rbm_pkg::CMD_PIXEL) words_done++;
  endtask

  // drop valid and wait out every pending result and the block's window pass
  task automatic settle();
    in_valid_i <= 1'b0;
    while (mean_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_regs(input int w, input int h, input int r);
    settle();
    cfg_we_i <= 1'b1; cfg_index_i <= rbm_pkg::CFG_WIDTH;
    cfg_data_i <= rbm_pkg::CFG_W'(w);
    @(posedge clk_i);
    fw_reg = rbm_pkg::FW_W'(w); restart_pos();
    cfg_index_i <= rbm_pkg::CFG_HEIGHT; cfg_data_i <= rbm_pkg::CFG_W'(h);
    @(posedge clk_i);
    fh_reg = rbm_pkg::FH_W'(h); restart_pos();
    cfg_index_i <= rbm_pkg::CFG_RADIUS; cfg_data_i <= rbm_pkg::CFG_W'(r);
    @(posedge clk_i);
    fr_reg = rbm_pkg::FR_W'(r); restart_pos();
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] rand_chan();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 8'h00;
    if (k == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic rbm_pkg::in_word_t rand_pixel();
    rbm_pkg::in_word_t p;
    p.command = rbm_pkg::CMD_PIXEL;
    p.chan0_in = rand_chan();
    p.chan1_in = rand_chan();
    p.chan2_in = rand_chan();
    return p;
  endfunction

  function automatic rbm_pkg::in_word_t flush_word();
    rbm_pkg::in_word_t p;
    p = rand_pixel();
    p.command = rbm_pkg::CMD_FLUSH;
    return p;
  endfunction

  // one frame: whole or cut short, with stray flushes mixed in and drain flushes after it
  task automatic run_frame(input bit broken);
    int w, h, r, total, sent, drain;
    w = eff_width();
    h = eff_height();
    r = int'(fr_reg);
    total = w * h;
    sent = broken ? $urandom_range(1, total) : total;
    if ($urandom_range(9) == 0) feed(flush_word());
    for (int i = 0; i < sent; i++) begin
      if ($urandom_range(99) < 3) feed(flush_word());
      feed(rand_pixel());
    end
    drain = (r * w + r < total) ? r * w + r : total;
    if (broken) drain = $urandom_range(0, drain);
    else drain += $urandom_range(0, 2);
    for (int i = 0; i < drain; i++) feed(flush_word());
  endtask

  // receiver: random stall, or one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (squeeze_req && !squeeze_done) begin
      out_stall_i <= 1'b1;
      hold_left <= 3000;
      squeeze_done <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // check each taken result word against the oldest prediction
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (mean_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_word_o);
        errors++;
      end else begin
        rbm_pkg::out_word_t e;
        e = mean_q.pop_front();
        if (out_word_o.chan0_mean !== e.chan0_mean || out_word_o.chan1_mean !== e.chan1_mean
            || out_word_o.chan2_mean !== e.chan2_mean
            || out_word_o.frame_end !== e.frame_end) begin
          $display("%0t: expected %h got %h", $time, e, out_word_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    bit has;
    rbm_pkg::out_word_t res;
    int base, span;

    fw_reg = 11'd640; fh_reg = 13'd480; fr_reg = 3'd1;
    restart_pos();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 1x1 frame, radius 0: every pixel comes back as itself and ends the frame
    write_regs(1, 1, 0);
    row.typed = 1'b1;
    row.word = '{rbm_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00};
    row.result = '{8'h00, 8'h00, 8'h00, 1'b1};
    rows.push_back(row);
    row.word = '{rbm_pkg::CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF};
    row.result = '{8'hFF, 8'hFF, 8'hFF, 1'b1};
    rows.push_back(row);
    row.word = '{rbm_pkg::CMD_PIXEL, 8'h12, 8'h80, 8'h7F};
    row.result = '{8'h12, 8'h80, 8'h7F, 1'b1};
    rows.push_back(row);
    row.word = '{rbm_pkg::CMD_PIXEL, 8'hA5, 8'h5A, 8'h01};
    row.result = '{8'hA5, 8'h5A, 8'h01, 1'b1};
    rows.push_back(row);
    row.typed = 1'b0;
    row.word = '{rbm_pkg::CMD_FLUSH, 8'hFF, 8'h00, 8'hFF};
    rows.push_back(row);
    row.word = '{rbm_pkg::CMD_FLUSH, 8'h00, 8'hFF, 8'h00};
    rows.push_back(row);
    foreach (rows[i]) begin
      send_word(rows[i].word, has, res);
      if (rows[i].typed) mean_q.push_back(rows[i].result);
      else if (has) mean_q.push_back(res);
    end

    // register extremes: clamped sizes, window larger than frame, tall frame cut short
    write_regs(0, 0, 7);
    run_frame(1'b0);
    write_regs(5, 3, 7);
    run_frame(1'b0);
    run_frame(1'b1);
    run_frame(1'b0);
    write_regs(2047, 1, 0);
    run_frame(1'b0);
    write_regs(1, 8191, 7);
    for (int i = 0; i < 40; i++) feed(rand_pixel());
    write_regs(3, 2, 4);
    run_frame(1'b0);

    // random phases; the first one also holds the receiver off for a long stretch
    base = words_done;
    span = (ITEM_GOAL - base) / 3;
    send_gap_pct <= 36;
    recv_stall_pct <= 47;
    write_regs(4, 4, 0);
    squeeze_req <= 1'b1;
    run_frame(1'b0);
    run_frame(1'b0);
    while (words_done < ITEM_GOAL) begin
      if (words_done - base > 2 * span) begin
        send_gap_pct <= 0;
        recv_stall_pct <= 0;
      end else if (words_done - base > span) begin
        send_gap_pct <= 47;
        recv_stall_pct <= 36;
      end
      write_regs($urandom_range(1, 6), $urandom_range(1, 5), $urandom_range(0, 7));
      run_frame($urandom_range(99) < 15);
    end

    settle();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
src/rbm_pkg.sv
src/rbm_ram.sv
src/rbm_lane.sv
src/rgb_box_mean_filter.sv
src/rbm_check.sv
test/tb_top.sv
